// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication form of the above.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ===== hdl/cme_pkg.sv =====
// Package for the cubic multibrot escape-time block: payload types, constants.
// No dependencies.
package cme_pkg;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned IterBits  = 10;

  localparam logic [2:0] RegXOrigin = 3'd0;
  localparam logic [2:0] RegYOrigin = 3'd1;
  localparam logic [2:0] RegXStep   = 3'd2;
  localparam logic [2:0] RegYStep   = 3'd3;
  localparam logic [2:0] RegMaxIter = 3'd4;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic        escaped;
    logic [9:0]  iterations;
    logic [31:0] magnitude_sq;
  } pix_out_t;

  // Mapped point handed from the front part to the back part.
  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } point_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== hdl/cme_front.sv =====
// Front part: maps pixel indices to c in a multiply stage, then an add stage.
// Depends on cme_pkg.
module cme_front import cme_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pix_in_t            in_data_i,
  input  logic signed [31:0] x_origin_i,
  input  logic signed [31:0] y_origin_i,
  input  logic signed [31:0] x_step_i,
  input  logic signed [31:0] y_step_i,
  output logic               pt_valid_o,
  input  logic               pt_ready_i,
  output point_t             pt_o
);
  logic               s1_vld_q, s2_vld_q;
  logic signed [44:0] px_q, py_q;
  point_t             pt_q;
  logic               s2_free, s1_adv;

  assign s2_free    = !s2_vld_q || pt_ready_i;
  assign s1_adv     = s1_vld_q && s2_free;
  assign in_ready_o = !s1_vld_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_vld_q <= in_valid_i;
      if (s2_free) s2_vld_q <= s1_vld_q;
    end
  end

  // Product of a 12-bit index and 32-bit step fits in 45 bits.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      px_q <= 45'($signed({1'b0, in_data_i.pixel_x[CoordBits-1:0]})) * 45'(x_step_i);
      py_q <= 45'($signed({1'b0, in_data_i.pixel_y[CoordBits-1:0]})) * 45'(y_step_i);
    end
    if (s1_adv) begin
      pt_q.cr <= sat32(48'(px_q) + 48'(x_origin_i));
      pt_q.ci <= sat32(48'(py_q) + 48'(y_origin_i));
    end
  end

  assign pt_valid_o = s2_vld_q;
  assign pt_o       = pt_q;
endmodule

// ===== hdl/cme_fifo.sv =====
// Two-entry queue of mapped points between the front and back parts.
// Depends on cme_pkg.
module cme_fifo import cme_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_valid_i,
  output logic   wr_ready_o,
  input  point_t wr_data_i,
  output logic   rd_valid_o,
  input  logic   rd_ready_i,
  output point_t rd_data_o
);
  point_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// ===== hdl/cme_back.sv =====
// Back part: iterates z = z^3 + c with one shared 32x32 multiplier sequencer.
// Depends on cme_pkg.
module cme_back import cme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pt_valid_i,
  output logic        pt_ready_o,
  input  point_t      pt_i,
  input  logic [9:0]  max_iter_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pix_out_t    out_data_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSqR  = 3'd1;
  localparam logic [2:0] StSqI  = 3'd2;
  localparam logic [2:0] StTest = 3'd3;
  localparam logic [2:0] StMulI = 3'd4;
  localparam logic [2:0] StMulR = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]         st_q, st_d;
  logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
  logic [63:0]        sqr_q, sqi_q;
  logic [9:0]         n_q;
  logic signed [31:0] ta_q, tb_q;
  pix_out_t           res_q;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [64:0]        msum;
  logic [34:0]        magw;
  logic [36:0]        r2, i2;
  logic signed [36:0] ta, tb;

  // Shared multiplier operand select.
  always_comb begin
    unique case (st_q)
      StSqR:   begin ma = zr_q; mb = zr_q; end
      StSqI:   begin ma = zi_q; mb = zi_q; end
      StMulI:  begin ma = zi_q; mb = ta_q; end
      StMulR:  begin ma = zr_q; mb = tb_q; end
      default: begin ma = zr_q; mb = zr_q; end
    endcase
  end
  assign prod = ma * mb;

  assign msum = {1'b0, sqr_q} + {1'b0, sqi_q};
  assign magw = msum[64:30];
  // Below escape both squares are under 2^56, so r2, i2 < 2^29.
  assign r2 = {8'd0, sqr_q[55:27]};
  assign i2 = {8'd0, sqi_q[55:27]};
  assign ta = $signed(r2 + r2 + r2 - i2);
  assign tb = $signed(r2 - i2 - i2 - i2);

  assign out_valid_o = st_q == StDone;
  assign out_data_o  = res_q;
  assign pt_ready_o  = st_q == StIdle;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (pt_valid_i) st_d = StSqR;
      StSqR:   st_d = StSqI;
      StSqI:   st_d = StTest;
      StTest:  st_d = (n_q < max_iter_i && msum < 65'h100000000000000) ? StMulI : StDone;
      StMulI:  st_d = StMulR;
      StMulR:  st_d = StSqR;
      StDone:  if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else         st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (pt_valid_i) begin
        cr_q <= pt_i.cr; ci_q <= pt_i.ci;
        zr_q <= pt_i.cr; zi_q <= pt_i.ci;
        n_q  <= '0;
      end
      StSqR: sqr_q <= prod;
      StSqI: sqi_q <= prod;
      StTest: begin
        ta_q <= ta[31:0];
        tb_q <= tb[31:0];
        res_q.escaped      <= n_q < max_iter_i;
        res_q.iterations   <= n_q;
        res_q.magnitude_sq <= (magw[34:32] != 3'd0) ? 32'hffffffff : magw[31:0];
      end
      StMulI: zi_q <= sat32(48'(prod >>> 27) + 48'(ci_q));
      StMulR: begin
        zr_q <= sat32(48'(prod >>> 27) + 48'(cr_q));
        n_q  <= n_q + 10'd1;
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/cubic_multibrot_escape_time.sv =====
// Top level of the cubic multibrot escape-time block: register port, front, queue, back.
// Depends on cme_pkg, assert_macros.svh and the cme_* modules.
// Each pixel word maps to c = origin + index*step (Q5.27, saturated) in a two-stage front
// part, waits in a two-entry queue, and a back part iterates z = z^3 + c on one shared
// 32x32 multiplier: four multiplies plus a test step per iteration. The back part takes a
// new point only after its previous result has left, so it holds one point at a time.
// The front part maps the next words while the back part iterates. Registers sit at byte
// addresses 0,4,8,12,16 (x_origin, y_origin, x_step, y_step, max_iterations); write only
// when idle.
`include "assert_macros.svh"
module cubic_multibrot_escape_time import cme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pix_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pix_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic signed [31:0] x_origin_q, y_origin_q, x_step_q, y_step_q;
  logic [9:0]         max_iter_q;
  logic [2:0]         reg_idx;
  logic               fr_valid, fr_ready, bk_valid, bk_ready;
  point_t             fr_pt, bk_pt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Hold register writes to the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= -32'sd268435456;
      y_origin_q <= -32'sd268435456;
      x_step_q   <= 32'sd524288;
      y_step_q   <= 32'sd524288;
      max_iter_q <= 10'd50;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegXOrigin: x_origin_q <= pwdata;
        RegYOrigin: y_origin_q <= pwdata;
        RegXStep:   x_step_q   <= pwdata;
        RegYStep:   y_step_q   <= pwdata;
        RegMaxIter: max_iter_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegXOrigin: prdata = x_origin_q;
      RegYOrigin: prdata = y_origin_q;
      RegXStep:   prdata = x_step_q;
      RegYStep:   prdata = y_step_q;
      RegMaxIter: prdata = {22'd0, max_iter_q};
      default:    prdata = '0;
    endcase
  end

  cme_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .x_origin_i(x_origin_q), .y_origin_i(y_origin_q),
    .x_step_i(x_step_q), .y_step_i(y_step_q),
    .pt_valid_o(fr_valid), .pt_ready_i(fr_ready), .pt_o(fr_pt)
  );

  cme_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fr_valid), .wr_ready_o(fr_ready), .wr_data_i(fr_pt),
    .rd_valid_o(bk_valid), .rd_ready_i(bk_ready), .rd_data_o(bk_pt)
  );

  cme_back u_back (
    .clk_i, .rst_ni, .pt_valid_i(bk_valid), .pt_ready_o(bk_ready), .pt_i(bk_pt),
    .max_iter_i(max_iter_q), .out_valid_o, .out_ready_i, .out_data_o
  );

  // A finished result never reports more iterations than the limit.
  `ASSERT_IMP(a_iter_le_max, out_valid_o, out_data_o.iterations <= max_iter_q, "iterations over limit")
  // Escaped results stopped below the limit.
  `ASSERT_IMP(a_esc_below, out_valid_o && out_data_o.escaped, out_data_o.iterations < max_iter_q, "escape at limit")
  // A held result stays put until taken.
  `ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 $stable(out_data_o), "result changed while stalled")
endmodule
